// ----- sv/sha_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; used by sha_engine and sha256_stream_hasher_core.
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Control from the sequencer to the compression engine
    typedef struct packed {
        logic       shift;      // shift one byte into the block window
        logic [7:0] shift_data;
        logic       start;      // begin a 64-round compression
        logic       init;       // reload the chaining words with the initial values
    } t_eng_ctrl;

    function automatic t_word rotr(input t_word x, input int unsigned s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word ch_f(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word maj_f(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ----- sv/sha_engine.sv -----
// SHA-256 compression engine: 512-bit block window, one round per cycle,
// chaining words. Depends on sha_pkg.
module sha_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha_pkg::t_eng_ctrl   i_ctrl,
    output logic                 o_busy,
    output logic [255:0]         o_chain
);
    import sha_pkg::*;

    logic [511:0]       r_win;      // block bytes, oldest in the top bits
    t_word              r_v [8];    // working variables a..h
    t_word              r_chain [8];
    logic [ROUND_W-1:0] r_round;
    logic               r_busy;
    logic               r_fin;

    t_word w0, w1, w9, w14, w_new, t1, t2;
    t_word round_v [8];

    always_comb begin
        w0  = r_win[511:480];
        w1  = r_win[479:448];
        w9  = r_win[223:192];
        w14 = r_win[63:32];
        w_new = w0 + small_s0(w1) + w9 + small_s1(w14);
        t1 = r_v[7] + big_s1(r_v[4]) + ch_f(r_v[4], r_v[5], r_v[6]) + ROUND_K[r_round] + w0;
        t2 = big_s0(r_v[0]) + maj_f(r_v[0], r_v[1], r_v[2]);
        round_v[0] = t1 + t2;
        round_v[1] = r_v[0];
        round_v[2] = r_v[1];
        round_v[3] = r_v[2];
        round_v[4] = r_v[3] + t1;
        round_v[5] = r_v[4];
        round_v[6] = r_v[5];
        round_v[7] = r_v[6];
        for (int i = 0; i < 8; i++) begin
            o_chain[255 - 32*i -: 32] = r_chain[i];
        end
    end

    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= H_INIT[i];
        end else begin
            if (i_ctrl.init) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= H_INIT[i];
            end
            if (i_ctrl.start) begin
                r_busy  <= 1'b1;
                r_fin   <= 1'b0;
                r_round <= '0;
            end else if (r_busy && !r_fin) begin
                r_round <= r_round + 1'b1;
                if (&r_round) r_fin <= 1'b1;
            end else if (r_fin) begin
                // fold the working variables back into the chain
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_v <= r_chain;
        end else if (r_busy && !r_fin) begin
            r_v <= round_v;
        end
        // window doubles as the message schedule during the rounds
        if (i_ctrl.shift) begin
            r_win <= {r_win[503:0], i_ctrl.shift_data};
        end else if (r_busy && !r_fin) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

endmodule

// ----- sv/sha256_stream_hasher_core.sv -----
// SHA-256 stream hasher top level: byte intake, padding sequencer, digest output.
// Depends on sha_pkg and sha_engine.
//
// Takes one byte word per cycle while a 64-byte block fills. The word that completes
// a block holds the input off while one round unit runs the 64 rounds at one
// per cycle and then adds the result into the chaining words. On the end mark
// the sequencer shifts the padding (0x80, zeros, 64-bit big-endian bit length) into
// the block window one byte per cycle and runs one or two more compressions; the
// digest is loaded once the output register is free (one compression with 55 bytes
// buffered, two with 56 buffered, where the padding spills into a second block). The
// digest then goes to an output register and leaves as eight words, h0 first, one
// per cycle while the sink is ready; the next message may start while those words
// are still waiting to be taken.
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,   // message_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_number, rest zero
    output logic        o_m_tlast    // final_word
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLOCK,
        ST_PAD,
        ST_PAD_RUN,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [63:0]         r_len, n_len;
    logic                r_end, n_end;
    logic                r_pad_first, n_pad_first;
    logic                r_len_ok, n_len_ok;
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_word, n_word;
    logic [255:0]        r_dig, n_dig;

    t_eng_ctrl           eng_ctrl;
    logic                eng_busy;
    logic [255:0]        eng_chain;
    logic [FILL_W-1:0]   fill_inc;

    sha_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (eng_ctrl),
        .o_busy  (eng_busy),
        .o_chain (eng_chain)
    );

    assign fill_inc   = r_fill + 1'b1;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_word, r_dig[255:224]};
    assign o_m_tlast  = (r_word == 3'd7);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_end       = r_end;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_out_valid = r_out_valid;
        n_word      = r_word;
        n_dig       = r_dig;
        eng_ctrl    = '0;

        // drain the digest register
        if (r_out_valid && i_m_tready) begin
            n_dig  = {r_dig[223:0], 32'h0};
            n_word = r_word + 3'd1;
            if (r_word == 3'd7) n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser) begin
                        eng_ctrl.shift      = 1'b1;
                        eng_ctrl.shift_data = i_s_tdata;
                        n_fill = fill_inc;
                        n_len  = r_len + 64'd8;
                        if (&r_fill) begin
                            eng_ctrl.start = 1'b1;
                            n_end   = i_s_tlast;
                            n_state = ST_BLOCK;
                        end else if (i_s_tlast) begin
                            n_pad_first = 1'b1;
                            n_len_ok    = (fill_inc < FILL_W'(LEN_OFFSET));
                            n_state     = ST_PAD;
                        end
                    end else if (i_s_tlast) begin
                        n_pad_first = 1'b1;
                        n_len_ok    = (r_fill < FILL_W'(LEN_OFFSET));
                        n_state     = ST_PAD;
                    end
                end
            end
            ST_BLOCK: begin
                if (!eng_busy) begin
                    if (r_end) begin
                        n_pad_first = 1'b1;
                        n_len_ok    = 1'b1;
                        n_state     = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                eng_ctrl.shift = 1'b1;
                if (r_pad_first) begin
                    eng_ctrl.shift_data = PAD_BYTE;
                end else if (r_len_ok && r_fill >= FILL_W'(LEN_OFFSET)) begin
                    // length goes out most significant byte first
                    eng_ctrl.shift_data = r_len[{~r_fill[2:0], 3'b000} +: 8];
                end else begin
                    eng_ctrl.shift_data = 8'h00;
                end
                n_pad_first = 1'b0;
                n_fill      = fill_inc;
                if (&r_fill) begin
                    eng_ctrl.start = 1'b1;
                    n_state        = ST_PAD_RUN;
                end
            end
            ST_PAD_RUN: begin
                if (!eng_busy) begin
                    if (r_len_ok) begin
                        n_state = ST_DONE;
                    end else begin
                        n_len_ok = 1'b1;
                        n_state  = ST_PAD;
                    end
                end
            end
            ST_DONE: begin
                // hold until the previous digest has fully left
                if (!r_out_valid) begin
                    n_dig         = eng_chain;
                    n_word        = 3'd0;
                    n_out_valid   = 1'b1;
                    eng_ctrl.init = 1'b1;
                    n_fill        = '0;
                    n_len         = '0;
                    n_end         = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_end       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_out_valid <= 1'b0;
            r_word      <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_end       <= n_end;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_out_valid <= n_out_valid;
            r_word      <= n_word;
        end
        r_dig <= n_dig;
    end

`ifndef SYNTHESIS
    a_busy_in_run_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_busy |-> (r_state == ST_BLOCK || r_state == ST_PAD_RUN))
        else $error("compression running outside a run state");

    a_fill_zero_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLOCK || r_state == ST_PAD_RUN) |-> (r_fill == '0))
        else $error("fill count not wrapped while compressing");

    a_word_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast)
            |=> (o_m_tvalid && r_word == $past(r_word) + 3'd1))
        else $error("digest word sequence broken");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid) |=> (r_state == ST_DONE || !$past(i_m_tready)
            || $past(r_word) == 3'd7))
        else $error("digest loaded while previous words pending");
`endif

endmodule
